FILE: design/ssme_pkg.sv
package ssme_pkg;

    localparam int DEPTH  = 32;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [CNT_W-1:0]         count_t;
    typedef logic [IDX_W-1:0]         index_t;

    typedef enum logic [1:0] {
        CMD_LOAD_FIRST  = 2'd0,
        CMD_LOAD_SECOND = 2'd1,
        CMD_RUN         = 2'd2,
        CMD_NONE        = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        MODE_MERGE  = 2'd0,
        MODE_UNION  = 2'd1,
        MODE_INTER  = 2'd2,
        MODE_DIFF   = 2'd3
    } mode_t;

    typedef struct packed {
        logic load_first;
        logic load_second;
        logic start;
        logic step;
    } ssme_cmd_t;

    typedef struct packed {
        logic walk_done;
        logic slot_free;
    } ssme_status_t;

endpackage

FILE: design/ssme_if.sv
interface ssme_req_if;
    import ssme_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    data_t      value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface ssme_rsp_if;
    import ssme_pkg::*;
    logic  valid;
    logic  ready;
    data_t result_value;
    logic  last;
    logic  empty_res;

    modport source (output valid, output result_value, output last, output empty_res,
                    input ready);
    modport sink   (input valid, input result_value, input last, input empty_res,
                    output ready);
endinterface

interface ssme_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/ssme_ctrl.sv
module ssme_ctrl
    import ssme_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    input  logic [1:0]   req_command,
    output logic         req_ready,
    input  ssme_status_t status,
    output ssme_cmd_t    cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   req_fire;

    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;

    always_comb
    begin
        cmd             = '0;
        cmd.load_first  = req_fire && (req_command == CMD_LOAD_FIRST);
        cmd.load_second = req_fire && (req_command == CMD_LOAD_SECOND);
        cmd.start       = req_fire && (req_command == CMD_RUN);
        cmd.step        = (state_reg == ST_RUN) && status.slot_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (cmd.step && status.walk_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: design/ssme_datapath.sv
module ssme_datapath
    import ssme_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  ssme_cmd_t    cmd,
    input  data_t        req_value,
    output ssme_status_t status,
    ssme_cfg_if.sink     cfg,
    ssme_rsp_if.source   rsp
);

    data_t first_store [DEPTH];
    data_t second_store [DEPTH];

    count_t first_count_reg, first_count_next;
    count_t second_count_reg, second_count_next;
    count_t i_reg, i_next;
    count_t j_reg, j_next;
    logic [1:0] mode_reg;
    data_t a_data_reg;
    data_t b_data_reg;

    logic  pend_valid_reg, pend_valid_next;
    data_t pend_value_reg, pend_value_next;

    logic  out_valid_reg, out_valid_next;
    data_t out_value_reg;
    logic  out_last_reg;
    logic  out_empty_reg;

    logic  a_rem, b_rem;
    logic  a_lt_b, b_lt_a;
    logic  walk_done, emit, inc_i, inc_j;
    data_t emit_value;

    logic  push, push_last, push_empty;
    data_t push_value;

    assign cfg.ready = 1'b1;

    assign a_rem  = (i_reg < first_count_reg);
    assign b_rem  = (j_reg < second_count_reg);
    assign a_lt_b = (a_data_reg < b_data_reg);
    assign b_lt_a = (b_data_reg < a_data_reg);

    // one cursor step of the walk
    always_comb
    begin
        walk_done  = 1'b0;
        emit       = 1'b0;
        inc_i      = 1'b0;
        inc_j      = 1'b0;
        emit_value = a_data_reg;
        priority if (a_rem && b_rem)
        begin
            if (mode_reg == MODE_MERGE)
            begin
                emit = 1'b1;
                if (a_lt_b)
                begin
                    inc_i = 1'b1;
                end
                else
                begin
                    emit_value = b_data_reg;
                    inc_j      = 1'b1;
                end
            end
            else if (a_lt_b)
            begin
                emit  = (mode_reg != MODE_INTER);
                inc_i = 1'b1;
            end
            else if (b_lt_a)
            begin
                emit       = (mode_reg == MODE_UNION);
                emit_value = b_data_reg;
                inc_j      = 1'b1;
            end
            else
            begin
                emit  = (mode_reg == MODE_UNION) || (mode_reg == MODE_INTER);
                inc_i = 1'b1;
                inc_j = 1'b1;
            end
        end
        else if (a_rem && (mode_reg != MODE_INTER))
        begin
            emit  = 1'b1;
            inc_i = 1'b1;
        end
        else if (b_rem && ((mode_reg == MODE_MERGE) || (mode_reg == MODE_UNION)))
        begin
            emit       = 1'b1;
            emit_value = b_data_reg;
            inc_j      = 1'b1;
        end
        else
        begin
            walk_done = 1'b1;
        end
    end

    assign status.walk_done = walk_done;
    assign status.slot_free = !out_valid_reg || rsp.ready;

    // one item is held back so the final one can be marked last
    always_comb
    begin
        push            = 1'b0;
        push_value      = pend_value_reg;
        push_last       = 1'b0;
        push_empty      = 1'b0;
        pend_valid_next = pend_valid_reg;
        pend_value_next = pend_value_reg;
        if (cmd.start)
        begin
            pend_valid_next = 1'b0;
        end
        else if (cmd.step)
        begin
            if (walk_done)
            begin
                push            = 1'b1;
                push_last       = 1'b1;
                pend_valid_next = 1'b0;
                if (!pend_valid_reg)
                begin
                    push_value = '0;
                    push_empty = 1'b1;
                end
            end
            else if (emit)
            begin
                push            = pend_valid_reg;
                pend_valid_next = 1'b1;
                pend_value_next = emit_value;
            end
        end
    end

    always_comb
    begin
        i_next = i_reg;
        j_next = j_reg;
        if (cmd.start)
        begin
            i_next = '0;
            j_next = '0;
        end
        else if (cmd.step && !walk_done)
        begin
            if (inc_i)
            begin
                i_next = i_reg + count_t'(1);
            end
            if (inc_j)
            begin
                j_next = j_reg + count_t'(1);
            end
        end
    end

    always_comb
    begin
        first_count_next  = first_count_reg;
        second_count_next = second_count_reg;
        if (cmd.step && walk_done)
        begin
            first_count_next  = '0;
            second_count_next = '0;
        end
        if (cmd.load_first && (first_count_reg < count_t'(DEPTH)))
        begin
            first_count_next = first_count_reg + count_t'(1);
        end
        if (cmd.load_second && (second_count_reg < count_t'(DEPTH)))
        begin
            second_count_next = second_count_reg + count_t'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_count_reg  <= '0;
            second_count_reg <= '0;
            i_reg            <= '0;
            j_reg            <= '0;
            mode_reg         <= MODE_MERGE;
            pend_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            pend_valid_reg   <= pend_valid_next;
            out_valid_reg    <= out_valid_next;
            if (cfg.valid)
            begin
                mode_reg <= cfg.data;
            end
        end
    end

    // list storage and registered reads at the next cursor positions
    always_ff @(posedge clk)
    begin
        if (cmd.load_first && (first_count_reg < count_t'(DEPTH)))
        begin
            first_store[first_count_reg[IDX_W-1:0]] <= req_value;
        end
        if (cmd.load_second && (second_count_reg < count_t'(DEPTH)))
        begin
            second_store[second_count_reg[IDX_W-1:0]] <= req_value;
        end
        if (i_next < count_t'(DEPTH))
        begin
            a_data_reg <= first_store[i_next[IDX_W-1:0]];
        end
        if (j_next < count_t'(DEPTH))
        begin
            b_data_reg <= second_store[j_next[IDX_W-1:0]];
        end
        pend_value_reg <= pend_value_next;
        if (push)
        begin
            out_value_reg <= push_value;
            out_last_reg  <= push_last;
            out_empty_reg <= push_empty;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_value = out_value_reg;
    assign rsp.last         = out_last_reg;
    assign rsp.empty_res    = out_empty_reg;

endmodule

FILE: design/sorted_set_merge_engine.sv
// loads produce no result
// a run is a two-cursor walk with a single compare step, stepping only while the
// response slot is free; one result per cycle at best
// each result waits pending until the next emit; the final one until the walk ends
// rst_n is asynchronous active low: counts, cursors, mode and handshake state clear,
// list storage holds no defined value until loaded
module sorted_set_merge_engine
    import ssme_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ssme_req_if.sink   req,
    ssme_cfg_if.sink   cfg,
    ssme_rsp_if.source rsp
);

    ssme_cmd_t    cmd;
    ssme_status_t status;

    ssme_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_command (req.command),
        .req_ready   (req.ready),
        .status      (status),
        .cmd         (cmd)
    );

    ssme_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req_value (req.value),
        .status    (status),
        .cfg       (cfg),
        .rsp       (rsp)
    );

endmodule
